// File: sv/m2p_pkg.sv
// ----------------------------------------------------------------------------
// m2p_pkg
// Shared types, constants and the control store of the 2x2 matrix power unit.
// ----------------------------------------------------------------------------
package m2p_pkg;

  localparam int ElemBits = 32;
  localparam int ExpBits  = 31;
  localparam int Dim      = 2;
  localparam int NumSteps = 8;
  localparam int StepW    = $clog2(NumSteps);

  typedef logic [ElemBits-1:0]               elem_t;
  typedef elem_t [Dim-1:0][Dim-1:0]          mat_t;
  typedef elem_t [Dim-1:0][Dim-1:0][Dim-1:0] prod_t;
  typedef logic [ExpBits-1:0]                exp_t;
  typedef logic [StepW-1:0]                  step_t;

  // jump conditions; a false condition falls through to the next step
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_EXP_ZERO,
    COND_BIT_CLR,
    COND_OUT_BUSY
  } cond_e;

  // second operand of the matrix product; the first is always the base
  typedef enum logic {
    OP_ACC,
    OP_BASE
  } opsel_e;

  typedef struct packed {
    cond_e  cond;
    step_t  target;
    logic   take_req;
    opsel_e sel;
    logic   mul;
    logic   wr_acc;
    logic   wr_base;
    logic   shift_exp;
    logic   wr_out;
  } uword_t;

  typedef struct packed {
    logic   in_ready;
    logic   load;
    opsel_e sel;
    logic   mul;
    logic   wr_acc;
    logic   wr_base;
    logic   shift_exp;
    logic   wr_out;
  } ctrl_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
  } status_t;

  localparam step_t StepIdle   = step_t'(0);
  localparam step_t StepTestZ  = step_t'(1);
  localparam step_t StepTestB  = step_t'(2);
  localparam step_t StepMulAcc = step_t'(3);
  localparam step_t StepWrAcc  = step_t'(4);
  localparam step_t StepMulSq  = step_t'(5);
  localparam step_t StepWrSq   = step_t'(6);
  localparam step_t StepDone   = step_t'(7);

  function automatic uword_t ucode(step_t step);
    uword_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = StepIdle;
    w.sel    = OP_ACC;
    unique case (step)
      StepIdle: begin
        w.cond     = COND_NO_REQ;
        w.target   = StepIdle;
        w.take_req = 1'b1;
      end
      StepTestZ: begin
        w.cond   = COND_EXP_ZERO;
        w.target = StepDone;
      end
      StepTestB: begin
        w.cond   = COND_BIT_CLR;
        w.target = StepMulSq;
      end
      StepMulAcc: begin
        w.sel = OP_ACC;
        w.mul = 1'b1;
      end
      StepWrAcc: begin
        w.wr_acc = 1'b1;
      end
      StepMulSq: begin
        w.sel = OP_BASE;
        w.mul = 1'b1;
      end
      StepWrSq: begin
        w.wr_base   = 1'b1;
        w.shift_exp = 1'b1;
        w.cond      = COND_ALWAYS;
        w.target    = StepTestZ;
      end
      StepDone: begin
        w.cond   = COND_OUT_BUSY;
        w.target = StepDone;
        w.wr_out = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/m2p_if.sv
// ----------------------------------------------------------------------------
// m2p_in_if / m2p_out_if
// Valid/ready channels carrying the base matrix request and the power result.
// ----------------------------------------------------------------------------
interface m2p_in_if;
  import m2p_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [ElemBits-1:0] base_r0c0;
  logic signed [ElemBits-1:0] base_r0c1;
  logic signed [ElemBits-1:0] base_r1c0;
  logic signed [ElemBits-1:0] base_r1c1;
  logic        [ExpBits-1:0]  exponent;

  modport source (
    output valid, base_r0c0, base_r0c1, base_r1c0, base_r1c1, exponent,
    input  ready
  );
  modport sink (
    input  valid, base_r0c0, base_r0c1, base_r1c0, base_r1c1, exponent,
    output ready
  );
endinterface

interface m2p_out_if;
  import m2p_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [ElemBits-1:0] power_r0c0;
  logic signed [ElemBits-1:0] power_r0c1;
  logic signed [ElemBits-1:0] power_r1c0;
  logic signed [ElemBits-1:0] power_r1c1;

  modport source (
    output valid, power_r0c0, power_r0c1, power_r1c0, power_r1c1,
    input  ready
  );
  modport sink (
    input  valid, power_r0c0, power_r0c1, power_r1c0, power_r1c1,
    output ready
  );
endinterface

// File: sv/m2p_seq.sv
// ----------------------------------------------------------------------------
// m2p_seq
// Step counter and control store: decodes one control word per cycle and
// evaluates its conditional jump.
// ----------------------------------------------------------------------------
module m2p_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_busy_i,
  input  m2p_pkg::status_t status_i,
  output m2p_pkg::ctrl_t   ctrl_o
);
  import m2p_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   jump;

  assign word = ucode(step_q);

  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_REQ:   jump = !in_valid_i;
      COND_EXP_ZERO: jump = status_i.exp_zero;
      COND_BIT_CLR:  jump = !status_i.exp_lsb;
      COND_OUT_BUSY: jump = out_busy_i;
      default:       jump = 1'b1;
    endcase
  end

  always_comb begin
    step_d = jump ? word.target : step_t'(step_q + step_t'(1));
  end

  always_comb begin
    ctrl_o.in_ready  = word.take_req;
    ctrl_o.load      = word.take_req && in_valid_i;
    ctrl_o.sel       = word.sel;
    ctrl_o.mul       = word.mul;
    ctrl_o.wr_acc    = word.wr_acc;
    ctrl_o.wr_base   = word.wr_base;
    ctrl_o.shift_exp = word.shift_exp;
    // hold the result step while the output register is still occupied
    ctrl_o.wr_out    = word.wr_out && !out_busy_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: sv/m2p_datapath.sv
// ----------------------------------------------------------------------------
// m2p_datapath
// Base, accumulator and exponent registers, eight parallel multipliers with a
// product register, the pairwise adders and the result register.
// ----------------------------------------------------------------------------
module m2p_datapath (
  input  logic             clk_i,
  input  m2p_pkg::ctrl_t   ctrl_i,
  input  m2p_pkg::mat_t    base_i,
  input  m2p_pkg::exp_t    exp_i,
  output m2p_pkg::status_t status_o,
  output m2p_pkg::mat_t    result_o
);
  import m2p_pkg::*;

  mat_t  base_q, acc_q, res_q;
  mat_t  opb, sum;
  mat_t  ident;
  prod_t prod_q, prod_d;
  exp_t  exp_q;

  assign opb = (ctrl_i.sel == OP_ACC) ? acc_q : base_q;

  always_comb begin
    ident       = '0;
    ident[0][0] = elem_t'(1);
    ident[1][1] = elem_t'(1);
  end

  // prod[r][c][k] = base[r][k] * opb[k][c], low bits only
  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      for (int c = 0; c < Dim; c++) begin
        for (int k = 0; k < Dim; k++) begin
          prod_d[r][c][k] = base_q[r][k] * opb[k][c];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      for (int c = 0; c < Dim; c++) begin
        sum[r][c] = prod_q[r][c][0] + prod_q[r][c][1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.load) begin
      base_q <= base_i;
    end else if (ctrl_i.wr_base) begin
      base_q <= sum;
    end
    if (ctrl_i.load) begin
      acc_q <= ident;
    end else if (ctrl_i.wr_acc) begin
      acc_q <= sum;
    end
    if (ctrl_i.load) begin
      exp_q <= exp_i;
    end else if (ctrl_i.shift_exp) begin
      exp_q <= exp_q >> 1;
    end
    if (ctrl_i.wr_out) begin
      res_q <= acc_q;
    end
  end

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.exp_lsb  = exp_q[0];
  assign result_o          = res_q;

endmodule

// File: sv/matrix2x2_power.sv
// ----------------------------------------------------------------------------
// matrix2x2_power
// Raises a 2x2 matrix of wrapping 32-bit integers to a power by square and
// multiply, driven by a small microprogram.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; each exponent bit costs two test steps
//   plus a matrix product (8 multipliers into the product register, then adders)
//   for the squaring and another one for a set bit.
// Reset: the step counter returns to idle and the output channel empties.
// ----------------------------------------------------------------------------
module matrix2x2_power (
  input  logic clk_i,
  input  logic rst_ni,
  m2p_in_if.sink    in_i,
  m2p_out_if.source out_o
);
  import m2p_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  mat_t    base_in, result;
  logic    out_valid_q, out_valid_d;
  logic    out_busy;

  assign base_in[0][0] = elem_t'(in_i.base_r0c0);
  assign base_in[0][1] = elem_t'(in_i.base_r0c1);
  assign base_in[1][0] = elem_t'(in_i.base_r1c0);
  assign base_in[1][1] = elem_t'(in_i.base_r1c1);

  assign out_busy = out_valid_q && !out_o.ready;

  m2p_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_busy_i (out_busy),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  m2p_datapath u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .base_i   (base_in),
    .exp_i    (in_i.exponent),
    .status_o (status),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.wr_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign in_i.ready       = ctrl.in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.power_r0c0 = $signed(result[0][0]);
  assign out_o.power_r0c1 = $signed(result[0][1]);
  assign out_o.power_r1c0 = $signed(result[1][0]);
  assign out_o.power_r1c1 = $signed(result[1][1]);

  // after taking a request, stay busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while previous one in progress");

  // the result is captured only once the exponent has been fully consumed
  a_out_exp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_out |-> status.exp_zero)
    else $error("result written with exponent bits left");

  // an accumulator or base update always follows a product capture
  a_wr_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_acc || ctrl.wr_base) |-> $past(ctrl.mul))
    else $error("matrix update without product capture");

endmodule
